@@ rtl/cesu8_pkg.sv @@
// Shared types, codes and helpers for the CESU-8 / UTF-8 transcoder.
// Used by cesu8_ctrl, cesu8_dpath and cesu8_utf8_transcoder_core.
package cesu8_pkg;

  localparam int unsigned WinMax = 6;
  localparam int unsigned CntW   = 3;

  // result event codes
  localparam logic [2:0] EV_PASS      = 3'd0;
  localparam logic [2:0] EV_CONV      = 3'd1;
  localparam logic [2:0] EV_UNPAIRED  = 3'd2;
  localparam logic [2:0] EV_INVALID   = 3'd3;
  localparam logic [2:0] EV_MALFORMED = 3'd4;

  // output byte source
  localparam logic [1:0] SEL_HEAD  = 2'd0;
  localparam logic [1:0] SEL_QMARK = 2'd1;
  localparam logic [1:0] SEL_FWD   = 2'd2;
  localparam logic [1:0] SEL_REV   = 2'd3;

  localparam logic [7:0] LeadCesu = 8'hED;
  localparam logic [7:0] Qmark    = 8'h3F;

  typedef struct packed {
    logic            load;
    logic            emit;
    logic [1:0]      sel;
    logic [2:0]      idx;
    logic [2:0]      ev;
    logic            last;
    logic [CntW-1:0] shift;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            head_lead;
    logic            have_need;
    logic            fwd_pair;
    logic            fwd_surr;
    logic            rev_bad_cont;
    logic            rev_bad_plane;
    logic            eos;
    logic            more1;
    logic            more3;
    logic            more4;
    logic            slot_free;
  } sts_t;

  function automatic logic is_lead(input logic dir, input logic [7:0] b);
    return dir ? (b[7:3] == 5'b11110) : (b == LeadCesu);
  endfunction

endpackage

@@ rtl/cesu8_ctrl.sv @@
// Sequencer for the transcoder, using cesu8_pkg: picks one window
// action and emits at most one result byte per cycle unless stalled.
module cesu8_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              dir_i,
  input  logic              fix_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cesu8_pkg::sts_t   sts_i,
  output cesu8_pkg::cmd_t   cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PROC = 1'b1;

  localparam logic [1:0] MD_SCAN = 2'd0;
  localparam logic [1:0] MD_FWD  = 2'd1;
  localparam logic [1:0] MD_REV  = 2'd2;
  localparam logic [1:0] MD_PASS = 2'd3;

  logic       state_q, state_d;
  logic [1:0] mode_q, mode_d;
  logic [2:0] idx_q, idx_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PROC;
          mode_d     = MD_SCAN;
          idx_d      = '0;
        end
      end
      ST_PROC: begin
        if (sts_i.slot_free) begin
          case (mode_q)
            MD_SCAN: begin
              if (sts_i.cnt == '0) begin
                state_d = ST_IDLE;
              end else if (!sts_i.head_lead || (!sts_i.have_need && sts_i.eos)) begin
                cmd_o.emit  = 1'b1;
                cmd_o.sel   = cesu8_pkg::SEL_HEAD;
                cmd_o.ev    = cesu8_pkg::EV_PASS;
                cmd_o.shift = 3'd1;
                cmd_o.last  = !sts_i.more1;
              end else if (!sts_i.have_need) begin
                // lead byte waiting for the rest of its window
                state_d = ST_IDLE;
              end else if (!dir_i) begin
                cmd_o.emit = 1'b1;
                if (sts_i.fwd_pair) begin
                  cmd_o.sel = cesu8_pkg::SEL_FWD;
                  cmd_o.ev  = cesu8_pkg::EV_CONV;
                  mode_d    = MD_FWD;
                  idx_d     = 3'd1;
                end else if (sts_i.fwd_surr && fix_i) begin
                  cmd_o.sel   = cesu8_pkg::SEL_QMARK;
                  cmd_o.ev    = cesu8_pkg::EV_UNPAIRED;
                  cmd_o.shift = 3'd3;
                  cmd_o.last  = !sts_i.more3;
                end else if (sts_i.fwd_surr) begin
                  cmd_o.sel   = cesu8_pkg::SEL_HEAD;
                  cmd_o.ev    = cesu8_pkg::EV_UNPAIRED;
                  cmd_o.shift = 3'd1;
                  mode_d      = MD_PASS;
                  idx_d       = 3'd1;
                end else begin
                  cmd_o.sel   = cesu8_pkg::SEL_HEAD;
                  cmd_o.ev    = cesu8_pkg::EV_PASS;
                  cmd_o.shift = 3'd1;
                  cmd_o.last  = !sts_i.more1;
                end
              end else begin
                cmd_o.emit = 1'b1;
                if (sts_i.rev_bad_cont) begin
                  cmd_o.sel   = cesu8_pkg::SEL_HEAD;
                  cmd_o.ev    = cesu8_pkg::EV_MALFORMED;
                  cmd_o.shift = 3'd1;
                  cmd_o.last  = !sts_i.more1;
                end else if (sts_i.rev_bad_plane && fix_i) begin
                  cmd_o.sel   = cesu8_pkg::SEL_QMARK;
                  cmd_o.ev    = cesu8_pkg::EV_INVALID;
                  cmd_o.shift = 3'd4;
                  cmd_o.last  = !sts_i.more4;
                end else if (sts_i.rev_bad_plane) begin
                  cmd_o.sel   = cesu8_pkg::SEL_HEAD;
                  cmd_o.ev    = cesu8_pkg::EV_INVALID;
                  cmd_o.shift = 3'd1;
                  cmd_o.last  = !sts_i.more1;
                end else begin
                  cmd_o.sel = cesu8_pkg::SEL_REV;
                  cmd_o.ev  = cesu8_pkg::EV_CONV;
                  mode_d    = MD_REV;
                  idx_d     = 3'd1;
                end
              end
            end
            MD_PASS: begin
              // rest of an unpaired surrogate, passed as is
              cmd_o.emit  = 1'b1;
              cmd_o.sel   = cesu8_pkg::SEL_HEAD;
              cmd_o.ev    = cesu8_pkg::EV_UNPAIRED;
              cmd_o.shift = 3'd1;
              if (idx_q == 3'd2) begin
                cmd_o.last = !sts_i.more1;
                mode_d     = MD_SCAN;
              end else begin
                idx_d = idx_q + 3'd1;
              end
            end
            MD_FWD: begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = cesu8_pkg::SEL_FWD;
              cmd_o.ev   = cesu8_pkg::EV_CONV;
              cmd_o.idx  = idx_q;
              if (idx_q == 3'd3) begin
                cmd_o.shift = 3'd6;
                cmd_o.last  = 1'b1;
                mode_d      = MD_SCAN;
              end else begin
                idx_d = idx_q + 3'd1;
              end
            end
            MD_REV: begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = cesu8_pkg::SEL_REV;
              cmd_o.ev   = cesu8_pkg::EV_CONV;
              cmd_o.idx  = idx_q;
              if (idx_q == 3'd5) begin
                cmd_o.shift = 3'd4;
                cmd_o.last  = 1'b1;
                mode_d      = MD_SCAN;
              end else begin
                idx_d = idx_q + 3'd1;
              end
            end
            default: mode_d = MD_SCAN;
          endcase
          if (cmd_o.emit && cmd_o.last) begin
            state_d = ST_IDLE;
            mode_d  = MD_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MD_SCAN;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ rtl/cesu8_dpath.sv @@
// Datapath: six-byte window shift register, pattern checks, byte builders
// and the output register. Depends on cesu8_pkg.
module cesu8_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            dir_i,
  input  logic            dir_wr_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_eos_i,
  input  cesu8_pkg::cmd_t cmd_i,
  output cesu8_pkg::sts_t sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      out_event_o,
  output logic            out_last_o
);

  localparam int unsigned CntW = cesu8_pkg::CntW;

  logic [7:0]      win_q [cesu8_pkg::WinMax];
  logic [7:0]      win_d [cesu8_pkg::WinMax];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            eos_q;
  logic            ovalid_q;
  logic [7:0]      obyte_q;
  logic [2:0]      oev_q;
  logic            olast_q;

  logic            slot_free;
  logic [CntW-1:0] need;
  logic            high, low;
  logic [4:0]      pl_rev, pl_fwd;
  logic [3:0]      pl_rev_m1;
  logic [5:0]      ww_rev;
  logic [7:0]      fwd_byte, rev_byte, res_byte;

  function automatic logic more_after(input logic [CntW-1:0] cnt, input logic [CntW-1:0] k,
                                      input logic [7:0] wk, input logic eos,
                                      input logic dir);
    logic [CntW-1:0] rest;
    logic [CntW-1:0] nd;
    nd   = dir ? 3'd4 : 3'd6;
    rest = cnt - k;
    return (cnt > k) && (eos || !cesu8_pkg::is_lead(dir, wk) || (rest >= nd));
  endfunction

  assign slot_free = !ovalid_q || out_ready_i;
  assign need      = dir_i ? 3'd4 : 3'd6;

  assign high = (win_q[1][7:4] == 4'hA) && (win_q[2][7:6] == 2'b10);
  assign low  = (win_q[1][7:4] == 4'hB) && (win_q[2][7:6] == 2'b10);

  // plane bits of a four-byte code, and of a surrogate pair plus one
  assign pl_rev    = {win_q[0][2:0], win_q[1][5:4]};
  assign pl_rev_m1 = 4'(pl_rev - 5'd1);
  assign pl_fwd    = {1'b0, win_q[1][3:0]} + 5'd1;
  assign ww_rev    = {win_q[1][3:0], win_q[2][5:4]};

  always_comb begin
    sts_o               = '0;
    sts_o.cnt           = cnt_q;
    sts_o.head_lead     = cesu8_pkg::is_lead(dir_i, win_q[0]);
    sts_o.have_need     = (cnt_q >= need);
    sts_o.fwd_surr      = high || low;
    sts_o.fwd_pair      = high && (win_q[3] == cesu8_pkg::LeadCesu) &&
                          (win_q[4][7:4] == 4'hB) && (win_q[5][7:6] == 2'b10);
    sts_o.rev_bad_cont  = (win_q[1][7:6] != 2'b10) || (win_q[2][7:6] != 2'b10) ||
                          (win_q[3][7:6] != 2'b10);
    sts_o.rev_bad_plane = (pl_rev == 5'd0) || (pl_rev > 5'd16);
    sts_o.eos           = eos_q;
    sts_o.more1         = more_after(cnt_q, 3'd1, win_q[1], eos_q, dir_i);
    sts_o.more3         = more_after(cnt_q, 3'd3, win_q[3], eos_q, dir_i);
    sts_o.more4         = more_after(cnt_q, 3'd4, win_q[4], eos_q, dir_i);
    sts_o.slot_free     = slot_free;
  end

  always_comb begin
    case (cmd_i.idx)
      3'd0:    fwd_byte = {5'b11110, pl_fwd[4:2]};
      3'd1:    fwd_byte = {2'b10, pl_fwd[1:0], win_q[2][5:2]};
      3'd2:    fwd_byte = {2'b10, win_q[2][1:0], win_q[4][3:0]};
      default: fwd_byte = win_q[5];
    endcase
    case (cmd_i.idx)
      3'd0:    rev_byte = cesu8_pkg::LeadCesu;
      3'd1:    rev_byte = {4'hA, pl_rev_m1};
      3'd2:    rev_byte = {2'b10, ww_rev};
      3'd3:    rev_byte = cesu8_pkg::LeadCesu;
      3'd4:    rev_byte = {4'hB, win_q[2][3:0]};
      default: rev_byte = win_q[3];
    endcase
    case (cmd_i.sel)
      cesu8_pkg::SEL_HEAD:  res_byte = win_q[0];
      cesu8_pkg::SEL_QMARK: res_byte = cesu8_pkg::Qmark;
      cesu8_pkg::SEL_FWD:   res_byte = fwd_byte;
      cesu8_pkg::SEL_REV:   res_byte = rev_byte;
      default:              res_byte = win_q[0];
    endcase
  end

  // window update: append at the fill point or drop from the front
  always_comb begin
    logic [3:0] src;
    src = '0;
    for (int i = 0; i < cesu8_pkg::WinMax; i++) begin
      src      = {1'b0, 3'(i)} + {1'b0, cmd_i.shift};
      win_d[i] = win_q[i];
      if ((cmd_i.shift != '0) && (src < 4'(cesu8_pkg::WinMax))) begin
        win_d[i] = win_q[src[2:0]];
      end
    end
    if (cmd_i.load) begin
      win_d[cnt_q] = in_byte_i;
    end
    if (dir_wr_i) begin
      cnt_d = '0;
    end else if (cmd_i.load) begin
      cnt_d = cnt_q + 3'd1;
    end else if (cmd_i.shift >= cnt_q) begin
      cnt_d = (cmd_i.shift == '0) ? cnt_q : '0;
    end else begin
      cnt_d = cnt_q - cmd_i.shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      eos_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load) begin
        eos_q <= in_eos_i;
      end
      if (slot_free) begin
        ovalid_q <= cmd_i.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (slot_free && cmd_i.emit) begin
      obyte_q <= res_byte;
      oev_q   <= cmd_i.ev;
      olast_q <= cmd_i.last;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_event_o = oev_q;
  assign out_last_o  = olast_q;

endmodule

@@ rtl/cesu8_utf8_transcoder_core.sv @@
// Top level of the CESU-8 / UTF-8 transcoder: APB register file, stream
// ports, sequencer and datapath. Depends on cesu8_pkg, cesu8_ctrl, cesu8_dpath.

// Byte-stream transcoder. direction (0x0) picks CESU-8 to UTF-8 (0) or UTF-8
// to CESU-8 (1); writing it drops any bytes held in the window. fix_invalid
// (0x4) replaces unpaired surrogates and four-byte codes with a bad plane by
// '?'. Each input byte is loaded into the window first; the sequencer then
// releases its results, the most when a whole surrogate pair or four-byte
// code is rewritten. Results leave the single-byte output register at one
// byte per cycle while the sink keeps m_axis_tready high. s_axis_tready
// returns as soon as the last result of a byte has been loaded into the
// output register, or once the byte yields no more results, so a new byte
// is taken only after the results of the previous one. Results carry
// the event code on m_axis_tuser and mark the final byte of each input on
// m_axis_tlast; s_axis_tlast flushes the held bytes unchanged.
module cesu8_utf8_transcoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_stream
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output logic        m_axis_tlast    // last_of_run
);

  logic            dir_q, fix_q;
  logic            wr_en, dir_wr;
  cesu8_pkg::cmd_t cmd;
  cesu8_pkg::sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign dir_wr = wr_en && !paddr[2];
  assign prdata = paddr[2] ? {31'b0, fix_q} : {31'b0, dir_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      fix_q <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2]) begin
        fix_q <= pwdata[0];
      end else begin
        dir_q <= pwdata[0];
      end
    end
  end

  cesu8_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dir_i      (dir_q),
    .fix_i      (fix_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cesu8_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_i       (dir_q),
    .dir_wr_i    (dir_wr),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_event_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  // an idle block always has room to append the next byte
  a_room_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (sts.cnt < 3'd6))
    else $error("window full while accepting");

  // after an end-of-stream byte the window is flushed before the next transfer
  a_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && sts.eos) |-> (sts.cnt == 3'd0))
    else $error("window not flushed at end of stream");

  // a transfer always moves the block out of its ready state
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after an input transfer");

  // the input side only reopens after a final result or with nothing emitted
  a_last_before_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && !cmd.last) |=> !s_axis_tready)
    else $error("ready while results of a byte are pending");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for cesu8_utf8_transcoder_core: byte stream in,
// converted bytes with event codes out, checked against an in-bench predictor.
// Depends on cesu8_pkg and the transcoder RTL.
`timescale 1ns / 100ps

module tb;

  localparam logic [2:0] ADDR_DIRECTION = 3'd0;
  localparam logic [2:0] ADDR_FIX       = 3'd4;
  localparam int unsigned WIN_DEPTH     = 6;
  localparam int unsigned SETTLE_CYC    = 16;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam time         TIMEOUT_NS    = 5_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] ev;
    logic       last;
  } out_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0; // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic [2:0]  m_axis_tuser;         // [2:0] event_res
  logic        m_axis_tlast;         // last_of_run

  cesu8_utf8_transcoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  in_item_t    pending_bytes[$];
  out_item_t   expected_bytes[$];
  out_item_t   step_res[$];
  logic [7:0]  win_q[WIN_DEPTH];
  int unsigned win_n      = 0;
  logic        mode_rev   = 1'b0;
  logic        mode_fix   = 1'b0;
  int unsigned mismatches = 0;
  int unsigned n_pushed   = 0;
  logic        byte_taken = 1'b0;
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int unsigned src_gap    = 0;
  int unsigned snk_stall  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic opens_window(logic [7:0] b);
    return mode_rev ? (b[7:3] == 5'b11110) : (b == cesu8_pkg::LeadCesu);
  endfunction

  function automatic void emit_res(logic [7:0] b, logic [2:0] ev);
    out_item_t r;
    r.data = b;
    r.ev   = ev;
    r.last = 1'b0;
    if (step_res.size() < WIN_DEPTH) step_res.push_back(r);
  endfunction

  function automatic void drop_win(int unsigned k);
    if (k >= win_n) begin
      win_n = 0;
    end else begin
      for (int unsigned i = 0; i < win_n - k; i++) win_q[i] = win_q[i + k];
      win_n = win_n - k;
    end
  endfunction

  function automatic void pass_win(int unsigned k, logic [2:0] ev);
    for (int unsigned i = 0; i < k && i < win_n; i++) emit_res(win_q[i], ev);
    drop_win(k);
  endfunction

  // surrogate pair -> four-byte code, or unpaired surrogate handling
  function automatic void decide_cesu();
    logic       hi, lo, pair;
    logic [4:0] pl;
    logic [5:0] ww;
    hi   = (win_q[1][7:4] == 4'hA) && is_cont(win_q[2]);
    lo   = (win_q[1][7:4] == 4'hB) && is_cont(win_q[2]);
    pair = hi && (win_q[3] == cesu8_pkg::LeadCesu) && (win_q[4][7:4] == 4'hB) &&
           is_cont(win_q[5]);
    if (pair) begin
      pl = {1'b0, win_q[1][3:0]} + 5'd1;
      ww = win_q[2][5:0];
      emit_res({5'b11110, pl[4:2]}, cesu8_pkg::EV_CONV);
      emit_res({2'b10, pl[1:0], ww[5:2]}, cesu8_pkg::EV_CONV);
      emit_res({2'b10, ww[1:0], win_q[4][3:0]}, cesu8_pkg::EV_CONV);
      emit_res(win_q[5], cesu8_pkg::EV_CONV);
      drop_win(6);
    end else if (hi || lo) begin
      if (mode_fix) begin
        emit_res(cesu8_pkg::Qmark, cesu8_pkg::EV_UNPAIRED);
        drop_win(3);
      end else begin
        pass_win(3, cesu8_pkg::EV_UNPAIRED);
      end
    end else begin
      pass_win(1, cesu8_pkg::EV_PASS);
    end
  endfunction

  // four-byte code -> surrogate pair, or malformed and bad-plane handling
  function automatic void decide_utf8();
    logic [4:0] pl, pm;
    logic [5:0] ww;
    if (!is_cont(win_q[1]) || !is_cont(win_q[2]) || !is_cont(win_q[3])) begin
      pass_win(1, cesu8_pkg::EV_MALFORMED);
    end else begin
      pl = {win_q[0][2:0], win_q[1][5:4]};
      if (pl == 5'd0 || pl > 5'd16) begin
        if (mode_fix) begin
          emit_res(cesu8_pkg::Qmark, cesu8_pkg::EV_INVALID);
          drop_win(4);
        end else begin
          pass_win(1, cesu8_pkg::EV_INVALID);
        end
      end else begin
        pm = pl - 5'd1;
        ww = {win_q[1][3:0], win_q[2][5:4]};
        emit_res(cesu8_pkg::LeadCesu, cesu8_pkg::EV_CONV);
        emit_res({4'hA, pm[3:0]}, cesu8_pkg::EV_CONV);
        emit_res({2'b10, ww}, cesu8_pkg::EV_CONV);
        emit_res(cesu8_pkg::LeadCesu, cesu8_pkg::EV_CONV);
        emit_res({4'hB, win_q[2][3:0]}, cesu8_pkg::EV_CONV);
        emit_res(win_q[3], cesu8_pkg::EV_CONV);
        drop_win(4);
      end
    end
  endfunction

  function automatic void transcode_step(logic [7:0] b, logic eos);
    int unsigned need;
    out_item_t   r;
    step_res.delete();
    need = mode_rev ? 4 : 6;
    if (win_n < WIN_DEPTH) begin
      win_q[win_n] = b;
      win_n++;
    end
    while (win_n > 0) begin
      if (!opens_window(win_q[0])) pass_win(1, cesu8_pkg::EV_PASS);
      else if (win_n < need) break;
      else if (mode_rev) decide_utf8();
      else decide_cesu();
    end
    if (eos) pass_win(win_n, cesu8_pkg::EV_PASS);
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) expected_bytes.push_back(step_res[i]);
  endfunction

  // ------------------------------------------------------ driver and monitor

  always @(negedge clk_i) begin : src_drv
    logic     nv;
    in_item_t it;
    nv = s_axis_tvalid;
    it = {s_axis_tdata, s_axis_tlast};
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      byte_taken = 1'b0;
      nv = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (src_idle_on && $urandom_range(0, 9) == 0) begin
        src_gap = $urandom_range(1, 14) - 1;
      end else if (pending_bytes.size() > 0) begin
        it = pending_bytes.pop_front();
        nv = 1'b1;
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= it.data;
    s_axis_tlast  <= it.eos;
  end

  always @(negedge clk_i) begin : snk_drv
    logic rdy;
    rdy = 1'b1;
    if (snk_stall > 0) begin
      snk_stall--;
      rdy = 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
      snk_stall = $urandom_range(1, 14) - 1;
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin : mon
    out_item_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected transfer: byte %h ev %0d last %b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tuser !== want.ev ||
              m_axis_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: exp byte %h ev %0d last %b, got %h ev %0d last %b",
                       want.data, want.ev, want.last,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        transcode_step(s_axis_tdata, s_axis_tlast);
        byte_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic reg_write(logic [2:0] addr, logic val);
    logic [31:0] word;
    word    = $urandom();
    word[0] = val;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_DIRECTION) begin
      mode_rev = val;
      win_n    = 0;
    end else begin
      mode_fix = val;
    end
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[0] !== val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("register readback at %h: exp %b got %b", addr, val, prdata[0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(logic rev, logic fix);
    reg_write(ADDR_DIRECTION, rev);
    reg_write(ADDR_FIX, fix);
  endtask

  // wait until every byte was taken and every result has come back
  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic void push_byte(logic [7:0] b, logic eos);
    in_item_t it;
    it.data = b;
    it.eos  = eos;
    pending_bytes.push_back(it);
    n_pushed++;
  endfunction

  function automatic void push_tail(logic [7:0] b);
    push_byte(b, $urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_cont();
    logic [7:0] b;
    b = rand_byte();
    return {2'b10, b[5:0]};
  endfunction

  function automatic logic [7:0] rand_noncont();
    logic [7:0] b;
    b = rand_byte();
    if (b[7:6] == 2'b10) b[6] = 1'b1;
    return b;
  endfunction

  function automatic void push_noise();
    int unsigned n;
    n = $urandom_range(1, 3);
    for (int unsigned i = 0; i < n; i++) push_tail(rand_byte());
  endfunction

  function automatic void gen_cesu_seq();
    logic [3:0] n1, n2;
    n1 = 4'($urandom_range(0, 15));
    n2 = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_byte({4'hA, n1}, 1'b0);
        push_byte(rand_cont(), 1'b0);
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_byte({4'hB, n2}, 1'b0);
        push_tail(rand_cont());
      end
      4: begin
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_byte({4'hA, n1}, 1'b0);
        push_byte(rand_cont(), 1'b0);
        push_noise();
      end
      5: begin
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_byte({4'hB, n1}, 1'b0);
        push_tail(rand_cont());
      end
      6: begin
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_tail(rand_byte());
      end
      7: begin
        // pair with damaged inner bytes
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_byte({4'hA, n1}, 1'b0);
        push_byte(rand_byte(), 1'b0);
        push_byte(cesu8_pkg::LeadCesu, 1'b0);
        push_byte(rand_byte(), 1'b0);
        push_tail(rand_byte());
      end
      default: push_noise();
    endcase
  endfunction

  function automatic void gen_utf8_seq();
    logic [4:0] pl;
    logic [3:0] n1;
    logic [7:0] seq[4];
    int unsigned kind, bad;
    kind = $urandom_range(0, 9);
    n1   = 4'($urandom_range(0, 15));
    if (kind == 4) pl = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
    else pl = 5'($urandom_range(1, 16));
    seq[0] = {5'b11110, pl[4:2]};
    seq[1] = {2'b10, pl[1:0], n1};
    seq[2] = rand_cont();
    seq[3] = rand_cont();
    case (kind)
      0, 1, 2, 3, 4: begin
        for (int unsigned i = 0; i < 3; i++) push_byte(seq[i], 1'b0);
        push_tail(seq[3]);
      end
      5: begin
        bad = $urandom_range(1, 3);
        seq[bad] = rand_noncont();
        for (int unsigned i = 0; i < 3; i++) push_byte(seq[i], 1'b0);
        push_tail(seq[3]);
      end
      6: begin
        // code cut short by the end of the stream
        bad = $urandom_range(0, 2);
        for (int unsigned i = 0; i < bad; i++) push_byte(seq[i], 1'b0);
        push_byte(seq[bad], 1'b1);
      end
      default: push_noise();
    endcase
  endfunction

  task automatic random_block(int unsigned n);
    int unsigned half, target;
    half   = n_pushed + n / 2;
    target = n_pushed + n;
    for (int pass = 0; pass < 2; pass++) begin
      src_idle_on = $urandom_range(0, 3) != 0;
      snk_idle_on = $urandom_range(0, 3) != 0;
      while (n_pushed < (pass == 0 ? half : target)) begin
        if (mode_rev) gen_utf8_seq();
        else gen_cesu_seq();
      end
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // CESU-8 to UTF-8, passing invalid input through
    set_mode(1'b0, 1'b0);
    push_byte(cesu8_pkg::LeadCesu, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(cesu8_pkg::LeadCesu, 1'b0); push_byte(8'hB0, 1'b0); push_byte(8'h80, 1'b0);
    // lone low surrogate, then bytes that pass
    push_byte(cesu8_pkg::LeadCesu, 1'b0); push_byte(8'hB5, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h41, 1'b0);
    drain();

    // lone high surrogate fixed, trailing lead flushed by end of stream
    set_mode(1'b0, 1'b1);
    push_byte(cesu8_pkg::LeadCesu, 1'b0); push_byte(8'hAF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'h7F, 1'b0); push_byte(cesu8_pkg::LeadCesu, 1'b0); push_byte(8'h41, 1'b1);
    drain();
    random_block(100);

    set_mode(1'b1, 1'b0);
    random_block(100);

    // overlong and too-large codes replaced
    set_mode(1'b1, 1'b1);
    push_byte(8'hF0, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    random_block(100);

    set_mode(1'b0, 1'b0);
    random_block(100);

    // final stretch without any idling
    set_mode(1'b1, 1'b0);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    while (src_gap != 0 || snk_stall != 0) @(posedge clk_i);
    while (n_pushed < 500) gen_utf8_seq();
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ cesu8_utf8_transcoder_core.f @@
rtl/cesu8_pkg.sv
rtl/cesu8_ctrl.sv
rtl/cesu8_dpath.sv
rtl/cesu8_utf8_transcoder_core.sv
dv/tb.sv
